// ----- rtl/omni_drive_command_mapper_top_defines.svh -----
// assertion macros for the drive command mapper checker
`ifndef OMNI_DRIVE_COMMAND_MAPPER_TOP_DEFINES_SVH
`define OMNI_DRIVE_COMMAND_MAPPER_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define OMD_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define OMD_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/omd_pkg.sv -----
`default_nettype none

package omd_pkg;

  localparam int unsigned IN_W  = 24;
  localparam int unsigned OUT_W = 48;
  localparam int unsigned OP_W  = 24;
  localparam int unsigned PRD_W = 48;

  typedef enum logic [2:0] {
    CMD_MODE      = 3'd0,
    CMD_STOP      = 3'd1,
    CMD_TRANSLATE = 3'd2,
    CMD_TRACTOR   = 3'd3,
    CMD_SPIN_L    = 3'd4,
    CMD_SPIN_R    = 3'd5,
    CMD_KNOB_BTN  = 3'd6,
    CMD_KNOB_VAL  = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    KACT_NONE  = 2'd0,
    KACT_WRITE = 2'd1,
    KACT_CLEAR = 2'd2
  } knob_act_e;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_FULL = 2'd1,
    MODE_HALF = 2'd2
  } drive_mode_e;

  // velocity slots, also the column order of the wheel matrix
  localparam logic [1:0] VEL_X    = 2'd0;
  localparam logic [1:0] VEL_Y    = 2'd1;
  localparam logic [1:0] VEL_SPIN = 2'd2;

  // signed q16 velocity gains
  localparam logic signed [OP_W-1:0] K_TRANS = 24'sd264176;
  localparam logic signed [OP_W-1:0] K_TRACT = 24'sd1769;
  localparam logic signed [OP_W-1:0] K_SPIN  = 24'sd694;

  localparam logic signed [PRD_W-1:0] VEL_HI    = 48'sd8388607;
  localparam logic signed [PRD_W-1:0] VEL_LO    = -48'sd8388608;
  localparam logic signed [PRD_W-1:0] RPM_HI    = 48'sd100;
  localparam logic signed [PRD_W-1:0] RPM_LO    = -48'sd100;
  localparam logic signed [PRD_W-1:0] RPM_HALF  = 48'sd536870912;

  // wheel matrix with the rpm factor folded in, signed q16
  function automatic logic signed [OP_W-1:0] wheel_coef(input logic [1:0] whl,
                                                        input logic [1:0] col);
    logic signed [OP_W-1:0] c;
    unique case ({whl, col})
      4'b0000: c = -24'sd6884;
      4'b0001: c = -24'sd14707;
      4'b0010: c = 24'sd1706806;
      4'b0100: c = -24'sd6884;
      4'b0101: c = 24'sd14707;
      4'b0110: c = 24'sd1706806;
      4'b1000: c = 24'sd16271;
      4'b1001: c = 24'sd0;
      4'b1010: c = 24'sd2356973;
      default: c = 24'sd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/omd_mul.sv -----
`default_nettype none

module omd_mul import omd_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic signed [OP_W-1:0]  a_i,
  input  wire logic signed [OP_W-1:0]  b_i,
  output logic signed [PRD_W-1:0]      p_o
);

  logic signed [PRD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ----- rtl/omni_drive_command_mapper_top.sv -----
`default_nettype none

// Pad event to omni drive goal mapper. One result item comes out per input item, always
// carrying all four goals and the drive mode after the event. Mode, stop and knob events
// go from acceptance through the decode and finish states back to ready; translate and
// tractor events add 11 products and spin events 10, which go one per
// cycle through the single shared 24x24 multiplier (one or two velocity updates, then the
// nine terms of the wheel matrix), followed by rounding, the 100 rpm check and the goal
// write. The block takes no new item while it works on one; a finished result waits in
// the output register and the block returns to ready, but the next item then holds in its
// last cycle until that register has been taken.
module omni_drive_command_mapper_top import omd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // knob_index[1:0], x_value[10:2], y_value[18:11], zero[23:19]
  input  wire logic [IN_W-1:0]   s_axis_tdata_i,
  // cmd[2:0]
  input  wire logic [2:0]        s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  // goal_left[7:0], goal_right[15:8], goal_rear[23:16], goal_head[31:24],
  // drive_mode[33:32], goals_changed[34], drive_rejected[35], knob_action[37:36],
  // knob_target[39:38], knob_value[47:40]
  output logic [OUT_W-1:0]       m_axis_tdata_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_RUN,
    S_DRAIN,
    S_CMT,
    S_FIN
  } state_e;

  typedef struct packed {
    logic       vld;
    logic       vel;
    logic [1:0] dst;
    logic [1:0] whl;
    logic [1:0] trm;
  } op_t;

  state_e                  state_q;
  cmd_e                    cmd_q;
  logic [1:0]              idx_q;
  logic signed [8:0]       x_q;
  logic signed [7:0]       y_q;
  drive_mode_e             mode_q;
  logic signed [OP_W-1:0]  vel_q [3];
  logic signed [7:0]       goal_q [4];
  logic signed [7:0]       rpm_q [3];
  logic [1:0]              vstep_q;
  logic [1:0]              whl_q;
  logic [1:0]              trm_q;
  op_t                     op_q;
  op_t                     op_d;
  logic signed [PRD_W-1:0] acc_q;
  logic signed [PRD_W-1:0] sum_q;
  logic                    chk_vld_q;
  logic [1:0]              chk_whl_q;
  logic                    chg_q;
  logic                    rej_q;
  knob_act_e               kact_q;
  logic [1:0]              ktgt_q;
  logic signed [7:0]       kval_q;
  logic                    m_valid_q;
  logic [OUT_W-1:0]        m_data_q;

  logic signed [OP_W-1:0]  x_ext;
  logic signed [OP_W-1:0]  y_ext;
  logic signed [OP_W-1:0]  mul_a;
  logic signed [OP_W-1:0]  mul_b;
  logic signed [PRD_W-1:0] prod;
  logic signed [PRD_W-1:0] vtmp;
  logic signed [PRD_W-1:0] vrnd;
  logic signed [OP_W-1:0]  vel_new;
  logic signed [PRD_W-1:0] stmp;
  logic signed [PRD_W-1:0] rpm_full;
  logic                    rpm_over;
  logic                    enabled;
  logic                    out_free;

  assign x_ext = {{(OP_W-9){x_q[8]}}, x_q};
  assign y_ext = {{(OP_W-8){y_q[7]}}, y_q};
  assign enabled = (mode_q == MODE_FULL) || (mode_q == MODE_HALF);
  assign out_free = !m_valid_q || m_axis_tready_i;

  // operand select for the issue slot
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    op_d  = '0;
    op_d.vld = (state_q == S_RUN);
    op_d.whl = whl_q;
    op_d.trm = trm_q;
    priority if (vstep_q == 2'd0) begin
      op_d.vel = 1'b1;
      if (cmd_q == CMD_TRANSLATE) begin
        mul_a = x_ext;
        mul_b = K_TRANS;
        op_d.dst = VEL_X;
      end else begin
        mul_a = -x_ext;
        mul_b = K_TRACT;
        op_d.dst = VEL_SPIN;
      end
    end else if (vstep_q == 2'd1) begin
      op_d.vel = 1'b1;
      unique case (cmd_q)
        CMD_TRANSLATE, CMD_TRACTOR: begin
          mul_a = y_ext;
          mul_b = K_TRANS;
          op_d.dst = VEL_Y;
        end
        CMD_SPIN_L: begin
          mul_a = x_ext;
          mul_b = K_SPIN;
          op_d.dst = VEL_SPIN;
        end
        default: begin
          mul_a = -x_ext;
          mul_b = K_SPIN;
          op_d.dst = VEL_SPIN;
        end
      endcase
    end else begin
      mul_a = vel_q[trm_q];
      mul_b = wheel_coef(whl_q, trm_q);
    end
  end

  omd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // velocity scaling: round half away from zero, then saturate
  always_comb begin
    vtmp = prod + ((mode_q == MODE_FULL) ? 48'sd2 : 48'sd4) - $signed({47'd0, prod[PRD_W-1]});
    vrnd = (mode_q == MODE_FULL) ? (vtmp >>> 2) : (vtmp >>> 3);
    if (vrnd > VEL_HI) begin
      vel_new = VEL_HI[OP_W-1:0];
    end else if (vrnd < VEL_LO) begin
      vel_new = VEL_LO[OP_W-1:0];
    end else begin
      vel_new = vrnd[OP_W-1:0];
    end
  end

  // wheel rpm rounding and limit check
  always_comb begin
    stmp     = sum_q + RPM_HALF - $signed({47'd0, sum_q[PRD_W-1]});
    rpm_full = stmp >>> 30;
    rpm_over = (rpm_full > RPM_HI) || (rpm_full < RPM_LO);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cmd_q     <= CMD_MODE;
      idx_q     <= '0;
      x_q       <= '0;
      y_q       <= '0;
      mode_q    <= MODE_HALF;
      for (int i = 0; i < 3; i++) begin
        vel_q[i] <= '0;
        rpm_q[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        goal_q[i] <= '0;
      end
      vstep_q   <= '0;
      whl_q     <= '0;
      trm_q     <= '0;
      op_q      <= '0;
      acc_q     <= '0;
      sum_q     <= '0;
      chk_vld_q <= 1'b0;
      chk_whl_q <= '0;
      chg_q     <= 1'b0;
      rej_q     <= 1'b0;
      kact_q    <= KACT_NONE;
      ktgt_q    <= '0;
      kval_q    <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      op_q      <= op_d;
      chk_vld_q <= 1'b0;

      if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      // use stage of the shared multiplier
      if (op_q.vld) begin
        if (op_q.vel) begin
          vel_q[op_q.dst] <= vel_new;
        end else begin
          unique case (op_q.trm)
            2'd0: acc_q <= prod;
            2'd1: acc_q <= acc_q + prod;
            default: begin
              sum_q     <= acc_q + prod;
              chk_vld_q <= 1'b1;
              chk_whl_q <= op_q.whl;
            end
          endcase
        end
      end

      if (chk_vld_q) begin
        rpm_q[chk_whl_q] <= rpm_full[7:0];
        if (rpm_over) begin
          rej_q <= 1'b1;
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            cmd_q   <= cmd_e'(s_axis_tuser_i);
            idx_q   <= s_axis_tdata_i[1:0];
            x_q     <= s_axis_tdata_i[10:2];
            y_q     <= s_axis_tdata_i[18:11];
            state_q <= S_DEC;
          end
        end
        S_DEC: begin
          chg_q   <= 1'b0;
          rej_q   <= 1'b0;
          kact_q  <= KACT_NONE;
          ktgt_q  <= '0;
          kval_q  <= '0;
          whl_q   <= '0;
          trm_q   <= '0;
          vstep_q <= ((cmd_q == CMD_TRANSLATE) || (cmd_q == CMD_TRACTOR)) ? 2'd0 : 2'd1;
          state_q <= S_FIN;
          if (cmd_q == CMD_MODE) begin
            if (x_q != '0) begin
              unique case (mode_q)
                MODE_OFF:  mode_q <= MODE_FULL;
                MODE_FULL: mode_q <= MODE_HALF;
                default:   mode_q <= MODE_OFF;
              endcase
            end
          end else if (enabled) begin
            unique case (cmd_q)
              CMD_STOP: begin
                goal_q[0] <= '0;
                goal_q[1] <= '0;
                goal_q[2] <= '0;
                chg_q     <= 1'b1;
                kact_q    <= KACT_CLEAR;
              end
              CMD_TRANSLATE, CMD_TRACTOR, CMD_SPIN_L, CMD_SPIN_R: begin
                state_q <= S_RUN;
              end
              CMD_KNOB_BTN: begin
                if (x_q != '0) begin
                  goal_q[idx_q] <= '0;
                  chg_q         <= 1'b1;
                  kact_q        <= KACT_WRITE;
                  ktgt_q        <= idx_q;
                end
              end
              default: begin
                goal_q[idx_q] <= x_q[7:0];
                chg_q         <= 1'b1;
              end
            endcase
          end else if (cmd_q == CMD_KNOB_VAL) begin
            kact_q <= KACT_WRITE;
            ktgt_q <= idx_q;
            kval_q <= goal_q[idx_q];
          end
        end
        S_RUN: begin
          if (vstep_q != 2'd2) begin
            vstep_q <= vstep_q + 2'd1;
          end else if (trm_q == 2'd2) begin
            trm_q <= '0;
            whl_q <= whl_q + 2'd1;
            if (whl_q == 2'd2) begin
              state_q <= S_DRAIN;
            end
          end else begin
            trm_q <= trm_q + 2'd1;
          end
        end
        S_DRAIN: begin
          if (chk_vld_q && (chk_whl_q == 2'd2)) begin
            state_q <= S_CMT;
          end
        end
        S_CMT: begin
          if (!rej_q) begin
            goal_q[0] <= -rpm_q[0];
            goal_q[1] <= rpm_q[1];
            goal_q[2] <= rpm_q[2];
            chg_q     <= 1'b1;
          end
          state_q <= S_FIN;
        end
        default: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {kval_q, ktgt_q, kact_q, rej_q, chg_q, mode_q,
                          goal_q[3], goal_q[2], goal_q[1], goal_q[0]};
            state_q   <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

`default_nettype wire

// ----- rtl/omd_chk.sv -----
`default_nettype none

`include "omni_drive_command_mapper_top_defines.svh"

module omd_chk import omd_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid_i,
  input wire logic             s_axis_tready_o,
  input wire logic             m_axis_tvalid_o,
  input wire logic             m_axis_tready_i,
  input wire logic [OUT_W-1:0] m_axis_tdata_o
);

  `OMD_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "result changed while stalled")

  `OMD_NEXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "ready right after an accepted item")

  `OMD_IMPLIES(a_reject_no_write, m_axis_tvalid_o && m_axis_tdata_o[35], !m_axis_tdata_o[34], "rejected drive wrote goals")

  `OMD_IMPLIES(a_clear_zero_wheels, m_axis_tvalid_o && (m_axis_tdata_o[37:36] == KACT_CLEAR), m_axis_tdata_o[34] && (m_axis_tdata_o[23:0] == 24'd0), "knob clear without zero wheel goals")

endmodule

bind omni_drive_command_mapper_top omd_chk u_omd_chk (.*);

`default_nettype wire

// ----- verif/omni_drive_command_mapper_top_tb.sv -----
`default_nettype none

module omni_drive_command_mapper_top_tb;
  import omd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned EVENT_TARGET  = 1500;
  localparam int unsigned SETTLE_CYCLES = 24;

  localparam longint TRANS_GAIN = 264176;
  localparam longint TRACT_GAIN = 1769;
  localparam longint SPIN_GAIN  = 694;
  localparam longint VEL_TOP    = 8388607;
  localparam longint VEL_BOTTOM = -8388608;
  localparam longint RPM_MAX    = 100;

  // goal_left in the lowest bits, as on m_axis_tdata_o
  typedef struct packed {
    logic signed [7:0] knob_value;
    logic [1:0]        knob_target;
    knob_act_e         knob_action;
    logic              drive_rejected;
    logic              goals_changed;
    drive_mode_e       drive_mode;
    logic signed [7:0] goal_head;
    logic signed [7:0] goal_rear;
    logic signed [7:0] goal_right;
    logic signed [7:0] goal_left;
  } goal_result_t;

  class goal_board;
    drive_mode_e       mode;
    longint            vel [3];
    logic signed [7:0] goals [4];
    longint            wheel_gain [3][3];
    goal_result_t      expected_goals [$];
    int unsigned       fail_count;

    function new();
      mode = MODE_HALF;
      foreach (vel[i]) vel[i] = 0;
      foreach (goals[i]) goals[i] = '0;
      wheel_gain[0][0] = -6884;
      wheel_gain[0][1] = -14707;
      wheel_gain[0][2] = 1706806;
      wheel_gain[1][0] = -6884;
      wheel_gain[1][1] = 14707;
      wheel_gain[1][2] = 1706806;
      wheel_gain[2][0] = 16271;
      wheel_gain[2][1] = 0;
      wheel_gain[2][2] = 2356973;
      fail_count = 0;
    endfunction

    // shift right, rounding half away from zero
    function longint round_off(longint a, int unsigned sh);
      longint unsigned mag;
      longint unsigned r;
      mag = (a < 0) ? longint'(-a) : a;
      r = (mag + (64'd1 << (sh - 1))) >> sh;
      return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function longint scale_velocity(longint v, longint k);
      longint r;
      r = round_off(v * k, (mode == MODE_FULL) ? 2 : 3);
      if (r > VEL_TOP) r = VEL_TOP;
      if (r < VEL_BOTTOM) r = VEL_BOTTOM;
      return r;
    endfunction

    // returns 1 when the wheel goals were written
    function bit update_wheels();
      longint rpm [3];
      longint acc;
      for (int w = 0; w < 3; w++) begin
        acc = wheel_gain[w][0] * vel[VEL_X] + wheel_gain[w][1] * vel[VEL_Y]
            + wheel_gain[w][2] * vel[VEL_SPIN];
        rpm[w] = round_off(acc, 30);
        if (rpm[w] > RPM_MAX || rpm[w] < -RPM_MAX) return 1'b0;
      end
      goals[0] = 8'(-rpm[0]);
      goals[1] = 8'(rpm[1]);
      goals[2] = 8'(rpm[2]);
      return 1'b1;
    endfunction

    function goal_result_t map_event(cmd_e cmd, logic [1:0] knob,
                                     logic signed [8:0] x, logic signed [7:0] y);
      goal_result_t res;
      bit           enabled;
      bit           drive;
      longint       xv;
      longint       yv;
      xv = x;
      yv = y;
      enabled = (mode == MODE_FULL) || (mode == MODE_HALF);
      drive = 1'b0;
      res = '0;
      res.knob_action = KACT_NONE;
      if (cmd == CMD_MODE) begin
        if (xv != 0) begin
          case (mode)
            MODE_OFF:  mode = MODE_FULL;
            MODE_FULL: mode = MODE_HALF;
            default:   mode = MODE_OFF;
          endcase
        end
      end else if (enabled) begin
        case (cmd)
          CMD_STOP: begin
            goals[0] = '0;
            goals[1] = '0;
            goals[2] = '0;
            res.goals_changed = 1'b1;
            res.knob_action = KACT_CLEAR;
          end
          CMD_TRANSLATE: begin
            vel[VEL_X] = scale_velocity(xv, TRANS_GAIN);
            vel[VEL_Y] = scale_velocity(yv, TRANS_GAIN);
            drive = 1'b1;
          end
          CMD_TRACTOR: begin
            vel[VEL_SPIN] = scale_velocity(-xv, TRACT_GAIN);
            vel[VEL_Y] = scale_velocity(yv, TRANS_GAIN);
            drive = 1'b1;
          end
          CMD_SPIN_L: begin
            vel[VEL_SPIN] = scale_velocity(xv, SPIN_GAIN);
            drive = 1'b1;
          end
          CMD_SPIN_R: begin
            vel[VEL_SPIN] = scale_velocity(-xv, SPIN_GAIN);
            drive = 1'b1;
          end
          CMD_KNOB_BTN: begin
            if (xv != 0) begin
              goals[knob] = '0;
              res.goals_changed = 1'b1;
              res.knob_action = KACT_WRITE;
              res.knob_target = knob;
            end
          end
          default: begin
            goals[knob] = x[7:0];
            res.goals_changed = 1'b1;
          end
        endcase
        if (drive) begin
          res.goals_changed = update_wheels();
          res.drive_rejected = !res.goals_changed;
        end
      end else if (cmd == CMD_KNOB_VAL) begin
        res.knob_action = KACT_WRITE;
        res.knob_target = knob;
        res.knob_value = goals[knob];
      end
      res.goal_left = goals[0];
      res.goal_right = goals[1];
      res.goal_rear = goals[2];
      res.goal_head = goals[3];
      res.drive_mode = mode;
      return res;
    endfunction

    function void note_event(cmd_e cmd, logic [1:0] knob,
                             logic signed [8:0] x, logic signed [7:0] y);
      expected_goals.push_back(map_event(cmd, knob, x, y));
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        fail_count++;
        $display("%0t: %s expected %0d got %0d", $time, name, $signed(want), $signed(got));
      end
    endfunction

    function void check_goals(logic [OUT_W-1:0] data);
      goal_result_t got;
      goal_result_t want;
      got = data;
      if (expected_goals.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result expected none got %h", $time, data);
        return;
      end
      want = expected_goals.pop_front();
      compare_field("goal_left", want.goal_left, got.goal_left);
      compare_field("goal_right", want.goal_right, got.goal_right);
      compare_field("goal_rear", want.goal_rear, got.goal_rear);
      compare_field("goal_head", want.goal_head, got.goal_head);
      compare_field("drive_mode", want.drive_mode, got.drive_mode);
      compare_field("goals_changed", want.goals_changed, got.goals_changed);
      compare_field("drive_rejected", want.drive_rejected, got.drive_rejected);
      compare_field("knob_action", want.knob_action, got.knob_action);
      compare_field("knob_target", want.knob_target, got.knob_target);
      compare_field("knob_value", want.knob_value, got.knob_value);
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid_i = 1'b0;
  logic            s_axis_tready_o;
  logic [IN_W-1:0] s_axis_tdata_i = '0;
  logic [2:0]      s_axis_tuser_i = '0;
  logic            m_axis_tvalid_o;
  logic            m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata_o;

  int unsigned cycle_count = 0;
  int unsigned sent_count = 0;
  goal_board   board = new();

  omni_drive_command_mapper_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) board.check_goals(m_axis_tdata_o);
      if (s_axis_tvalid_i && s_axis_tready_o)
        board.note_event(cmd_e'(s_axis_tuser_i), s_axis_tdata_i[1:0],
                         s_axis_tdata_i[10:2], s_axis_tdata_i[18:11]);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("omni_drive_command_mapper_top_tb NOT OK");
    $finish;
  end

  // result side stalls in spans of varying style
  initial begin
    int style;
    int span;
    int tick;
    tick = 0;
    forever begin
      style = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        case (style)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= 1'($urandom_range(0, 1));
          2: m_axis_tready_i <= ($urandom_range(0, 7) == 0);
          default: m_axis_tready_i <= (tick % 13 == 0);
        endcase
      end
    end
  end

  // starts and ends at a falling edge
  task automatic send_event(input cmd_e cmd, input logic [1:0] knob, input int x, input int y);
    s_axis_tuser_i <= cmd;
    s_axis_tdata_i <= {5'd0, 8'(y), 9'(x), knob};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic idle_sender(input int unsigned n);
    s_axis_tvalid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (board.expected_goals.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic int pick_x();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 255 : -255;
      1, 2, 3, 4: return int'($urandom_range(0, 80)) - 40;
      default: return int'($urandom_range(0, 510)) - 255;
    endcase
  endfunction

  initial begin
    int unsigned pick;
    int unsigned burst;
    cmd_e        cmd;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // limited mode: extremes, saturation and rejection
    send_event(CMD_TRANSLATE, 2'd0, 255, 100);
    send_event(CMD_TRANSLATE, 2'd1, -255, -100);
    send_event(CMD_TRANSLATE, 2'd2, 0, 0);
    send_event(CMD_TRANSLATE, 2'd3, 20, -30);
    send_event(CMD_TRACTOR, 2'd0, -255, 100);
    send_event(CMD_TRACTOR, 2'd1, 10, 5);
    send_event(CMD_SPIN_L, 2'd2, 255, 0);
    send_event(CMD_SPIN_R, 2'd3, -255, -1);
    send_event(CMD_KNOB_VAL, 2'd3, -128, 0);
    send_event(CMD_KNOB_VAL, 2'd0, 127, 0);
    send_event(CMD_KNOB_VAL, 2'd1, 200, 0);
    send_event(CMD_KNOB_VAL, 2'd2, -255, 0);
    send_event(CMD_KNOB_BTN, 2'd0, 0, 0);
    send_event(CMD_KNOB_BTN, 2'd3, 5, 0);
    send_event(CMD_STOP, 2'd0, 0, 0);
    send_event(CMD_MODE, 2'd0, 0, 0);
    // disabled: only knob values echo
    send_event(CMD_MODE, 2'd0, -1, 0);
    send_event(CMD_TRANSLATE, 2'd0, 100, 50);
    send_event(CMD_STOP, 2'd0, 0, 0);
    send_event(CMD_KNOB_BTN, 2'd1, 1, 0);
    send_event(CMD_KNOB_VAL, 2'd1, 77, 0);
    // unlimited mode
    send_event(CMD_MODE, 2'd0, 255, 0);
    send_event(CMD_TRANSLATE, 2'd0, 255, 100);
    send_event(CMD_SPIN_L, 2'd0, 255, 0);
    send_event(CMD_TRACTOR, 2'd0, -255, -100);
    send_event(CMD_MODE, 2'd0, -255, 0);

    idle_sender(1);
    wait_drained();

    while (sent_count < EVENT_TARGET) begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) cmd = CMD_MODE;
        else if (pick < 10) cmd = CMD_STOP;
        else if (pick < 35) cmd = CMD_TRANSLATE;
        else if (pick < 50) cmd = CMD_TRACTOR;
        else if (pick < 60) cmd = CMD_SPIN_L;
        else if (pick < 70) cmd = CMD_SPIN_R;
        else if (pick < 80) cmd = CMD_KNOB_BTN;
        else cmd = CMD_KNOB_VAL;
        send_event(cmd, 2'($urandom_range(0, 3)),
                   ($urandom_range(0, 4) == 0) ? 0 : pick_x(),
                   int'($urandom_range(0, 200)) - 100);
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 25));
    end

    idle_sender(1);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.fail_count == 0)
      $display("omni_drive_command_mapper_top_tb OK");
    else
      $display("omni_drive_command_mapper_top_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
